### hdl/fir8_pkg.sv
// Shared types and constants for the eight-tap low-pass FIR filter.
// Depends on nothing; the filter top level takes its defaults from here.
`default_nettype none

package fir8_pkg;

    // Coefficient format is fixed at Q1.15.
    localparam int COEF_WIDTH = 16;
    localparam int COEF_FRAC  = 15;
    localparam int COEF_COUNT = 8;

    // Coefficients are consumed four bits per cycle by the serial multiplier.
    localparam int DIGIT_WIDTH = 4;

    // The configuration index is one bit wider than the register list needs.
    localparam int CFG_ADDR_WIDTH = 4;

    // Default filter geometry.
    localparam int DEFAULT_TAPS         = 8;
    localparam int DEFAULT_SAMPLE_WIDTH = 16;

    typedef logic signed [COEF_WIDTH-1:0] coef_t;

    // Symmetric low-pass weights: 0.01, 0.05, 0.12, 0.32 rounded to Q1.15.
    localparam coef_t COEF_RESET [COEF_COUNT] = '{
        16'sd328, 16'sd1638, 16'sd3932, 16'sd10486,
        16'sd10486, 16'sd3932, 16'sd1638, 16'sd328
    };

endpackage

`default_nettype wire

### hdl/fir_lowpass_8tap.sv
// Top level of the low-pass FIR filter: sample store, coefficient registers,
// digit-serial multiply-accumulate, saturation and output register. Uses fir8_pkg.
`default_nettype none

// Streaming FIR filter with a circular store of TAPS samples. Each sample
// accepted on the input stream is written at the write pointer, then weighted
// by coefficient k against the store entry at (pointer + k) mod TAPS; the
// exact sum is shifted right by 15 with floor rounding and clipped to the
// sample width, with m_tuser flagging a clipped result. The multiplier takes
// the coefficient four bits per cycle out of a shift register. One sample
// is accepted while idle, accumulated digit by digit over every tap, and then
// handed to the output register; no new sample is accepted until then.
// The output register lets the next sample start while a result waits.
// Coefficients reset to the low-pass set and are written through cfg_we,
// cfg_addr and cfg_data; indexes beyond the list are ignored.
module fir_lowpass_8tap #(
    parameter int TAPS         = fir8_pkg::DEFAULT_TAPS,
    parameter int SAMPLE_WIDTH = fir8_pkg::DEFAULT_SAMPLE_WIDTH
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Input stream. s_tdata: sample_in in the low bits, zero padded.
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [(SAMPLE_WIDTH+7)/8*8-1:0]       s_tdata,
    // Output stream. m_tdata: sample_out in the low bits, zero padded.
    // m_tuser: saturated.
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [(SAMPLE_WIDTH+7)/8*8-1:0]            m_tdata,
    output logic                                       m_tuser,
    // Coefficient write port.
    input  wire logic                                  cfg_we,
    input  wire logic [fir8_pkg::CFG_ADDR_WIDTH-1:0]   cfg_addr,
    input  wire logic [fir8_pkg::COEF_WIDTH-1:0]       cfg_data
);

    localparam int DATA_W     = (SAMPLE_WIDTH + 7) / 8 * 8;
    localparam int PTR_W      = $clog2(TAPS);
    localparam int CIDX_W     = $clog2(fir8_pkg::COEF_COUNT);
    localparam int NUM_DIGITS = fir8_pkg::COEF_WIDTH / fir8_pkg::DIGIT_WIDTH;
    localparam int DIG_W      = $clog2(NUM_DIGITS);
    localparam int PP_W       = SAMPLE_WIDTH + fir8_pkg::DIGIT_WIDTH + 1;
    localparam int ACC_W      = SAMPLE_WIDTH + fir8_pkg::COEF_WIDTH + $clog2(TAPS);
    localparam int TOP_LSB    = fir8_pkg::COEF_FRAC + SAMPLE_WIDTH - 1;

    localparam logic [PTR_W-1:0] LAST_TAP   = PTR_W'(TAPS - 1);
    localparam logic [DIG_W-1:0] LAST_DIGIT = DIG_W'(NUM_DIGITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_FINISH
    } state_t;

    state_t                          state_reg, state_next;
    logic [PTR_W-1:0]                tap_reg, tap_next;
    logic [DIG_W-1:0]                digit_reg, digit_next;
    logic [PTR_W-1:0]                rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]                wr_ptr_reg, wr_ptr_next;
    logic [fir8_pkg::COEF_WIDTH-1:0] coef_sr_reg, coef_sr_next;
    logic signed [ACC_W-1:0]         acc_reg, acc_next;
    logic                            m_valid_reg, m_valid_next;
    logic [SAMPLE_WIDTH-1:0]         out_data_reg, out_data_next;
    logic                            out_sat_reg, out_sat_next;

    fir8_pkg::coef_t                 coef_reg [fir8_pkg::COEF_COUNT];
    logic signed [SAMPLE_WIDTH-1:0]  store_reg [TAPS];

    logic                            in_fire;
    logic                            out_fire;
    logic [PTR_W-1:0]                tap_inc;
    logic [PTR_W-1:0]                rd_ptr_inc;
    logic [PTR_W-1:0]                wr_ptr_inc;
    logic [CIDX_W-1:0]               coef_idx_next_tap;
    logic signed [SAMPLE_WIDTH-1:0]  samp_sel;
    logic signed [fir8_pkg::DIGIT_WIDTH:0] digit_ext;
    logic signed [PP_W-1:0]          pp;
    logic signed [ACC_W-1:0]         acc_add;
    logic [ACC_W-TOP_LSB-1:0]        acc_top;
    logic                            overflow;
    logic [SAMPLE_WIDTH-1:0]         sat_value;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_valid_reg && m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_W'(out_data_reg);
    assign m_tuser  = out_sat_reg;

    // Pointer arithmetic wraps at TAPS, which need not be a power of two.
    assign tap_inc    = tap_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == LAST_TAP) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_ptr_inc = (wr_ptr_reg == LAST_TAP) ? '0 : wr_ptr_reg + 1'b1;
    assign coef_idx_next_tap = CIDX_W'(tap_inc);

    // One digit of the coefficient times the selected sample. The top digit
    // carries the coefficient's sign; the lower digits are unsigned.
    assign samp_sel  = store_reg[rd_ptr_reg];
    assign digit_ext = (digit_reg == LAST_DIGIT)
                     ? {coef_sr_reg[fir8_pkg::DIGIT_WIDTH-1],
                        coef_sr_reg[fir8_pkg::DIGIT_WIDTH-1:0]}
                     : {1'b0, coef_sr_reg[fir8_pkg::DIGIT_WIDTH-1:0]};
    assign pp        = PP_W'(samp_sel) * PP_W'(digit_ext);
    assign acc_add   = ACC_W'(pp) <<< (int'(digit_reg) * fir8_pkg::DIGIT_WIDTH);

    // Floor shift by 15 is a bit select; the bits above the result must all
    // match its sign, or the value is clipped.
    assign acc_top   = acc_reg[ACC_W-1:TOP_LSB];
    assign overflow  = !((&acc_top) || !(|acc_top));
    assign sat_value = acc_reg[ACC_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                        : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    // Sequencer next-state logic.
    always_comb
    begin
        state_next    = state_reg;
        tap_next      = tap_reg;
        digit_next    = digit_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        coef_sr_next  = coef_sr_reg;
        acc_next      = acc_reg;
        m_valid_next  = out_fire ? 1'b0 : m_valid_reg;
        out_data_next = out_data_reg;
        out_sat_next  = out_sat_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next   = ST_MAC;
                    tap_next     = '0;
                    digit_next   = '0;
                    rd_ptr_next  = wr_ptr_reg;
                    wr_ptr_next  = wr_ptr_inc;
                    coef_sr_next = coef_reg[0];
                    acc_next     = '0;
                end
            end
            ST_MAC:
            begin
                acc_next     = acc_reg + acc_add;
                coef_sr_next = coef_sr_reg >> fir8_pkg::DIGIT_WIDTH;
                digit_next   = digit_reg + 1'b1;
                if (digit_reg == LAST_DIGIT)
                begin
                    digit_next   = '0;
                    coef_sr_next = coef_reg[coef_idx_next_tap];
                    rd_ptr_next  = rd_ptr_inc;
                    tap_next     = tap_inc;
                    if (tap_reg == LAST_TAP)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    out_data_next = overflow ? sat_value
                                             : acc_reg[fir8_pkg::COEF_FRAC +: SAMPLE_WIDTH];
                    out_sat_next  = overflow;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            tap_reg     <= '0;
            digit_reg   <= '0;
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            tap_reg     <= tap_next;
            digit_reg   <= digit_next;
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        coef_sr_reg  <= coef_sr_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
        out_sat_reg  <= out_sat_next;
    end

    // Sample store: the newest sample goes in at the write pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (in_fire)
        begin
            store_reg[wr_ptr_reg] <= s_tdata[SAMPLE_WIDTH-1:0];
        end
    end

    // Coefficient registers; writes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fir8_pkg::COEF_COUNT; i++)
            begin
                coef_reg[i] <= fir8_pkg::COEF_RESET[i];
            end
        end
        else if (cfg_we &&
                 (cfg_addr < fir8_pkg::CFG_ADDR_WIDTH'(fir8_pkg::COEF_COUNT)))
        begin
            coef_reg[cfg_addr[CIDX_W-1:0]] <= cfg_data;
        end
    end

`ifndef NO_ASSERTIONS
    // An accepted sample starts the first digit of the first tap.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_MAC) && (tap_reg == '0) && (digit_reg == '0))
        else $error("accepted sample did not start the multiply-accumulate");

    // The tap counter and read pointer stay inside the store while working.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (tap_reg <= LAST_TAP) && (rd_ptr_reg <= LAST_TAP))
        else $error("tap counter or read pointer out of range");

    // A clipped result sits at one end of the sample range.
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
            (out_data_reg == {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}) ||
            (out_data_reg == {1'b0, {(SAMPLE_WIDTH-1){1'b1}}}))
        else $error("saturation flag set on an unclipped value");
`endif

endmodule

`default_nettype wire
